// File: hdl/lpfd_pkg.sv
`timescale 1ns / 1ps

package lpfd_pkg;

	localparam int WORD_BYTES = 4;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_SMALL = 2'd2,
		KIND_LARGE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_LENGTH  = 4'b0001,
		PH_ID      = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_ERROR   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] message_id;
		logic [7:0]  payload_byte;
		logic [15:0] payload_length;
		logic        last_byte;
	} result_t;

endpackage

// File: hdl/lpfd_stream_if.sv
`timescale 1ns / 1ps

interface lpfd_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lpfd_parser.sv
`timescale 1ns / 1ps

module lpfd_parser #(
	parameter int MaxMessage = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	output logic             res_valid,
	output lpfd_pkg::result_t res
);
	import lpfd_pkg::*;

	localparam logic [31:0] LargeLimit = 32'(MaxMessage - WORD_BYTES);
	localparam logic [15:0] WordBytes16 = 16'(WORD_BYTES);
	localparam logic [31:0] WordBytes32 = 32'(WORD_BYTES);

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [31:0] length_q, length_d;
	logic [31:0] id_q, id_d;

	logic [31:0] shifted;
	logic [31:0] len_n;
	logic [31:0] id_n;
	logic [15:0] pos_inc;
	logic [15:0] plen;

	// byte lanes fill little-endian, lane picked by the low position bits
	assign shifted = 32'(data_byte) << {pos_q[1:0], 3'b000};
	assign len_n   = length_q | shifted;
	assign id_n    = id_q | shifted;
	assign pos_inc = pos_q + 16'd1;
	assign plen    = length_q[15:0] - WordBytes16;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		length_d  = length_q;
		id_d      = id_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_DATA, message_id: 32'd0, payload_byte: 8'd0,
			payload_length: 16'd0, last_byte: 1'b1};
		if (accept) begin
			case (phase_q)
				PH_LENGTH: begin
					length_d = len_n;
					pos_d    = pos_inc;
					if (pos_inc >= WordBytes16) begin
						pos_d = 16'd0;
						if (len_n < WordBytes32) begin
							phase_d   = PH_ERROR;
							res_valid = 1'b1;
							res.kind  = KIND_SMALL;
						end else if (len_n > LargeLimit) begin
							phase_d   = PH_ERROR;
							res_valid = 1'b1;
							res.kind  = KIND_LARGE;
						end else begin
							phase_d = PH_ID;
						end
					end
				end
				PH_ID: begin
					id_d  = id_n;
					pos_d = pos_inc;
					if (pos_inc >= WordBytes16) begin
						pos_d = 16'd0;
						if (length_q == WordBytes32) begin
							res_valid      = 1'b1;
							res.kind       = KIND_EMPTY;
							res.message_id = id_n;
							phase_d        = PH_LENGTH;
							length_d       = 32'd0;
							id_d           = 32'd0;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					pos_d              = pos_inc;
					res_valid          = 1'b1;
					res.kind           = KIND_DATA;
					res.message_id     = id_q;
					res.payload_byte   = data_byte;
					res.payload_length = plen;
					res.last_byte      = 1'b0;
					if (pos_inc >= plen) begin
						res.last_byte = 1'b1;
						phase_d       = PH_LENGTH;
						pos_d         = 16'd0;
						length_d      = 32'd0;
						id_d          = 32'd0;
					end
				end
				PH_ERROR: begin
					// sticky: bytes dropped until reset
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			pos_q    <= 16'd0;
			length_q <= 32'd0;
			id_q     <= 32'd0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			length_q <= length_d;
			id_q     <= id_d;
		end
	end

endmodule

// File: hdl/lpfd_out_buf.sv
`timescale 1ns / 1ps

module lpfd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpfd_pkg::result_t   push_data,
	output logic                has_room,
	lpfd_stream_if.source       results
);
	import lpfd_pkg::*;

	result_t     entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign has_room      = (count_q != 2'd2);
	assign results.valid = (count_q != 2'd0);
	assign results.data  = entry_q[rd_ptr_q];
	assign pop           = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/length_prefixed_frame_deframer_top.sv
`timescale 1ns / 1ps

// Length-prefixed deframer: takes one stream byte per cycle (4-byte LE length,
// 4-byte LE id, then length-4 payload bytes) and gives at most one result per
// byte, in the cycle after the byte's transfer, through a two-entry result
// buffer. Byte ready depends only on the buffer fill, so bytes move at one per
// cycle while results are taken; once both entries are full the byte side
// stalls until one leaves, so a result-side stall reaches the byte side through
// the registered fill count.
// Payload bytes come out as they arrive, tagged with id, payload length and
// a last flag. A bad length gives one error result, after which every byte is
// taken and dropped until reset.

module length_prefixed_frame_deframer_top #(
	parameter int MAX_MESSAGE = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	lpfd_stream_if.sink   byte_in,
	lpfd_stream_if.source results
);
	import lpfd_pkg::*;

	logic    accept;
	logic    has_room;
	logic    res_valid;
	result_t res;

	assign byte_in.ready = has_room;
	assign accept        = byte_in.valid && has_room;

	lpfd_parser #(
		.MaxMessage (MAX_MESSAGE)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (byte_in.data.data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	lpfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.has_room  (has_room),
		.results   (results)
	);

endmodule

// File: hdl/lpfd_checker.sv
`timescale 1ns / 1ps

module lpfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input lpfd_pkg::result_t out_data
);
	import lpfd_pkg::*;

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready &&
			(out_data.kind == KIND_SMALL || out_data.kind == KIND_LARGE)) begin
			err_seen_q <= 1'b1;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_SMALL || out_data.kind == KIND_LARGE)
		|-> out_data.last_byte && out_data.message_id == 32'd0
		&& out_data.payload_length == 16'd0)
		else $error("malformed error result");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_EMPTY
		|-> out_data.last_byte && out_data.payload_length == 16'd0)
		else $error("malformed empty-message result");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_DATA |-> out_data.payload_length != 16'd0)
		else $error("payload byte with zero payload length");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |-> !out_valid)
		else $error("result after error transfer");

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

// File: bench/deframer_result_checker.sv
`timescale 1ns / 1ps

module deframer_result_checker #(
	parameter int MAX_MESSAGE = 4096
) (
	input  logic   clk,
	input  logic   arst_n,
	lpfd_stream_if byte_in,
	lpfd_stream_if results,
	output int     fail_count,
	output int     outstanding
);
	import lpfd_pkg::*;

	phase_t      frame_phase;
	logic [15:0] field_count;
	logic [31:0] frame_length;
	logic [31:0] frame_id;

	result_t frame_outputs_due[$];
	result_t seen;
	result_t due;
	result_t made;
	bit      produced;
	int      misses;

	task automatic start_frame();
		frame_phase  = PH_LENGTH;
		field_count  = '0;
		frame_length = '0;
		frame_id     = '0;
	endtask

	// one stream byte through the frame parser; at most one output
	task automatic deframe_byte(input logic [7:0] b, output bit hit, output result_t r);
		logic [4:0]  sh;
		logic [15:0] plen;
		hit = 1'b0;
		r   = '0;
		sh  = {field_count[1:0], 3'b000};
		case (frame_phase)
			PH_LENGTH: begin
				frame_length = frame_length | ({24'd0, b} << sh);
				field_count  = field_count + 16'd1;
				if (field_count >= 16'(WORD_BYTES)) begin
					field_count = '0;
					if (frame_length < 32'(WORD_BYTES)) begin
						frame_phase = PH_ERROR;
						hit         = 1'b1;
						r.kind      = KIND_SMALL;
						r.last_byte = 1'b1;
					end else if (frame_length > 32'(MAX_MESSAGE - WORD_BYTES)) begin
						frame_phase = PH_ERROR;
						hit         = 1'b1;
						r.kind      = KIND_LARGE;
						r.last_byte = 1'b1;
					end else begin
						frame_phase = PH_ID;
					end
				end
			end
			PH_ID: begin
				frame_id    = frame_id | ({24'd0, b} << sh);
				field_count = field_count + 16'd1;
				if (field_count >= 16'(WORD_BYTES)) begin
					field_count = '0;
					if (frame_length == 32'(WORD_BYTES)) begin
						hit          = 1'b1;
						r.kind       = KIND_EMPTY;
						r.message_id = frame_id;
						r.last_byte  = 1'b1;
						start_frame();
					end else begin
						frame_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				plen             = 16'(frame_length - 32'(WORD_BYTES));
				field_count      = field_count + 16'd1;
				hit              = 1'b1;
				r.kind           = KIND_DATA;
				r.message_id     = frame_id;
				r.payload_byte   = b;
				r.payload_length = plen;
				r.last_byte      = (field_count >= plen);
				if (field_count >= plen)
					start_frame();
			end
			default: ; // sticky error: byte dropped
		endcase
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame();
			frame_outputs_due.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			misses = 0;
			if (results.valid && results.ready) begin
				seen = results.data;
				if (frame_outputs_due.size() == 0) begin
					$error("result with nothing due: kind %0d id 0x%0h byte 0x%0h",
						seen.kind, seen.message_id, seen.payload_byte);
					misses++;
				end else begin
					due = frame_outputs_due.pop_front();
					misses += field_differs("kind", 32'(due.kind), 32'(seen.kind));
					misses += field_differs("message_id", due.message_id, seen.message_id);
					misses += field_differs("payload_byte", 32'(due.payload_byte),
						32'(seen.payload_byte));
					misses += field_differs("payload_length", 32'(due.payload_length),
						32'(seen.payload_length));
					misses += field_differs("last_byte", 32'(due.last_byte),
						32'(seen.last_byte));
				end
			end
			if (byte_in.valid && byte_in.ready) begin
				deframe_byte(byte_in.data.data_byte, produced, made);
				if (produced)
					frame_outputs_due.push_back(made);
			end
			outstanding <= frame_outputs_due.size();
			fail_count  <= fail_count + misses;
		end
	end

endmodule

// File: bench/tb_length_prefixed_frame_deframer_top.sv
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer_top;
	import lpfd_pkg::*;

	localparam int MAX_MESSAGE = 4096;
	localparam int BYTE_TARGET = 1800;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int outstanding;
	int bytes_sent;
	int stall_cycles;
	int stream_base;
	logic [31:0] bad_length;

	lpfd_stream_if #(.item_t(byte_item_t)) byte_ch ();
	lpfd_stream_if #(.item_t(result_t))    result_ch ();

	length_prefixed_frame_deframer_top #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch),
		.results (result_ch)
	);

	deframer_result_checker #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_ch),
		.results     (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("length_prefixed_frame_deframer_top: mismatch");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.data.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			send_byte(w[8*i +: 8]);
	endtask

	task automatic send_frame(input logic [31:0] frame_length, input logic [31:0] id);
		send_word(frame_length);
		send_word(id);
		for (int i = 0; i < int'(frame_length) - WORD_BYTES; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic random_frame();
		int pick;
		int plen;
		logic [31:0] id;
		pick = $urandom_range(99);
		if (pick < 10)
			plen = 0;
		else if (pick < 80)
			plen = $urandom_range(16, 1);
		else
			plen = $urandom_range(300, 17);
		case ($urandom_range(9))
			0:       id = 32'h0000_0000;
			1:       id = 32'hFFFF_FFFF;
			default: id = $urandom();
		endcase
		send_frame(32'(plen + WORD_BYTES), id);
	endtask

	// hold the byte side off until every due result has come out
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		byte_ch.valid  = 1'b0;
		byte_ch.data   = '0;
		result_ch.ready = 1'b0;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		bytes_sent     = 0;
		stall_cycles   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame with all-ones id, then a two-byte payload at the byte extremes
		send_frame(32'd4, 32'hFFFF_FFFF);
		send_word(32'd6);
		send_word(32'h0000_0000);
		send_byte(8'h00);
		send_byte(8'hFF);

		for (int k = 0; k < 3; k++) begin
			case (k)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (k == 0) begin
				stream_base = bytes_sent;
			end
			while (bytes_sent < stream_base + BYTE_TARGET * (k + 1) / 3)
				random_frame();
			drain();
		end

		// the run closes in a state only reset leaves: either a bad length, or
		// the largest accepted length cut off partway through its payload
		if ($urandom_range(2) == 0) begin
			send_word(32'(MAX_MESSAGE - WORD_BYTES));
			send_word($urandom());
		end else begin
			if ($urandom_range(1) == 0) begin
				bad_length = 32'($urandom_range(3));
			end else begin
				case ($urandom_range(2))
					0:       bad_length = 32'(MAX_MESSAGE - WORD_BYTES + 1);
					1:       bad_length = 32'hFFFF_FFFF;
					default: bad_length = $urandom() | 32'h0001_0000;
				endcase
			end
			send_word(bad_length);
		end
		repeat ($urandom_range(40, 20))
			send_byte(8'($urandom_range(255)));
		drain();
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("length_prefixed_frame_deframer_top: match");
		else
			$display("length_prefixed_frame_deframer_top: mismatch");
		$finish;
	end

endmodule
